// ===== rtl/core/lhb_pkg.sv =====
// Shared codes, widths and types of the latency histogram binner.
package lhb_pkg;

   localparam int STAMP_W   = 64;
   localparam int KIND_W    = 2;
   localparam int SEL_W     = 3;
   localparam int CSR_IDX_W = 4;
   localparam int LIMIT_REGS = 7;
   localparam int OUT_SLOTS  = 6;
   localparam int RCNT_W     = 3;
   localparam int RSP_DEPTH  = 3;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 584;

   localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_RUN_DURATION = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_FIRST  = 4'd1;

   typedef enum logic [1:0] {
      OP_IDLE,
      OP_CLEAR,
      OP_COUNT,
      OP_REPORT
   } op_type;

endpackage

// ===== rtl/core/latency_histogram_binner.sv =====
// Top level of the latency histogram binner: timestamp gap histogram over memory-held bins.
//
// The block takes one transaction per clock on req_ while req_tready is high: start,
// sample and read items may follow one another in every cycle. A sample is binned in
// its accept cycle and its bin entry is read from a synchronous memory, updated in the
// next cycle and written back, with the last write forwarded to a following item on
// the same bin. A read's figures are assembled in the update stage and go out on rsp_
// through a three-entry result queue; req_tready drops only while that queue plus a
// read in flight would overflow. Start clears all bins at once through per-bin valid
// bits, so no clearing pass is needed. csr_ready is always high.
module latency_histogram_binner
   import lhb_pkg::*;
#(
   parameter int BIN_COUNT    = 8,
   parameter int RECENT_DEPTH = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // stamp [63:0], bin_select [66:64], zero [71:67]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind [1:0]
   input  logic [KIND_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // gap_sum [63:0], gap_tally [127:64], recent_count [130:128],
   // recent_time_0..5 [194:131] .. [514:451], largest_gap [578:515],
   // run_finished [579], zero [583:580]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [STAMP_W-1:0]    csr_data
);

   localparam int BIN_W   = $clog2(BIN_COUNT);
   localparam int FILL_W  = $clog2(RECENT_DEPTH + 1);
   localparam int SLOT_W  = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
   localparam int ENTRY_W = 2 * STAMP_W + FILL_W;

   // configuration
   logic [STAMP_W-1:0] duration_ff;
   logic [STAMP_W-1:0] limit_ff [LIMIT_REGS];

   // run state
   logic [STAMP_W-1:0] start_time_ff, start_time_in;
   logic [STAMP_W-1:0] prev_time_ff, prev_time_in;
   logic [STAMP_W-1:0] peak_ff, peak_in;
   logic               finished_ff, finished_in;

   // memories
   logic [ENTRY_W-1:0] bin_mem   [BIN_COUNT];
   logic [STAMP_W-1:0] stamp_mem [BIN_COUNT][RECENT_DEPTH];
   logic [ENTRY_W-1:0] rd_word_ff;
   logic [STAMP_W-1:0] stamp_row_ff [RECENT_DEPTH];
   logic [BIN_COUNT-1:0] valid_ff, valid_in;

   // update stage
   op_type             s1_op_ff, s1_op_in;
   logic [BIN_W-1:0]   s1_bin_ff;
   logic [SEL_W-1:0]   s1_sel_ff;
   logic [STAMP_W-1:0] s1_gap_ff;
   logic [STAMP_W-1:0] s1_stamp_ff;
   logic [STAMP_W-1:0] s1_peak_ff;
   logic               s1_fin_ff;

   // forwarding of the last write
   logic               fwd_valid_ff, fwd_valid_in;
   logic [BIN_W-1:0]   fwd_bin_ff;
   logic [ENTRY_W-1:0] fwd_word_ff;
   logic               fwd_stamp_we_ff;
   logic [SLOT_W-1:0]  fwd_slot_ff;
   logic [STAMP_W-1:0] fwd_stamp_ff;

   // result queue
   logic [RSP_DATA_W-1:0] rsp_mem_ff [RSP_DEPTH];
   logic [1:0]            rsp_wr_ff, rsp_wr_in;
   logic [1:0]            rsp_rd_ff, rsp_rd_in;
   logic [1:0]            rsp_count_ff, rsp_count_in;

   logic [KIND_W-1:0]  req_kind;
   logic [STAMP_W-1:0] req_stamp;
   logic [SEL_W-1:0]   req_sel;
   logic               req_accept;
   logic [STAMP_W-1:0] elapsed;
   logic [STAMP_W-1:0] gap;
   logic [BIN_W-1:0]   pick;
   logic [BIN_W-1:0]   rd_addr;

   logic               s1_hit;
   logic [ENTRY_W-1:0] cur_word;
   logic [STAMP_W-1:0] cur_total;
   logic [STAMP_W-1:0] cur_count;
   logic [FILL_W-1:0]  cur_fill;
   logic [STAMP_W-1:0] cur_row [RECENT_DEPTH];
   logic               stamp_we;
   logic [SLOT_W-1:0]  wr_slot;
   logic [ENTRY_W-1:0] wr_word;
   logic               do_write;
   logic               sel_ok;
   logic [7:0]         fill_ext;
   logic [7:0]         shown;
   logic [STAMP_W-1:0] recent [OUT_SLOTS];
   logic [RSP_DATA_W-1:0] rsp_word;
   logic               rsp_push;
   logic               rsp_pop;

   assign req_kind   = req_tuser;
   assign req_stamp  = req_tdata[STAMP_W-1:0];
   assign req_sel    = req_tdata[STAMP_W+SEL_W-1:STAMP_W];
   assign req_tready = ({1'b0, rsp_count_ff} + {2'b00, (s1_op_ff == OP_REPORT)})
                       < 3'(RSP_DEPTH);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign elapsed = req_stamp - start_time_ff;
   assign gap     = req_stamp - prev_time_ff;

   always_comb begin
      pick = BIN_W'(BIN_COUNT - 1);
      for (int i = BIN_COUNT - 2; i >= 0; i--) begin
         if (gap <= limit_ff[i]) begin
            pick = BIN_W'(i);
         end
      end
   end

   assign rd_addr = (req_kind == KIND_READ) ? req_sel[BIN_W-1:0] : pick;

   always_comb begin
      start_time_in = start_time_ff;
      prev_time_in  = prev_time_ff;
      peak_in       = peak_ff;
      finished_in   = finished_ff;
      s1_op_in      = OP_IDLE;
      if (req_accept) begin
         case (req_kind)
            KIND_START: begin
               start_time_in = req_stamp;
               prev_time_in  = req_stamp;
               peak_in       = '0;
               finished_in   = 1'b0;
               s1_op_in      = OP_CLEAR;
            end
            KIND_SAMPLE: begin
               if (!finished_ff) begin
                  if (elapsed >= duration_ff) begin
                     finished_in = 1'b1;
                  end else begin
                     prev_time_in = req_stamp;
                     if (gap > peak_ff) begin
                        peak_in = gap;
                     end
                     s1_op_in = OP_COUNT;
                  end
               end
            end
            KIND_READ: begin
               s1_op_in = OP_REPORT;
            end
            default: begin
               s1_op_in = OP_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff   <= '0;
         for (int i = 0; i < LIMIT_REGS; i++) begin
            limit_ff[i] <= '1;
         end
         start_time_ff <= '0;
         prev_time_ff  <= '0;
         peak_ff       <= '0;
         finished_ff   <= 1'b1;
         s1_op_ff      <= OP_IDLE;
         valid_ff      <= '0;
         fwd_valid_ff  <= 1'b0;
         rsp_wr_ff     <= '0;
         rsp_rd_ff     <= '0;
         rsp_count_ff  <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_RUN_DURATION) begin
               duration_ff <= csr_data;
            end
            for (int i = 0; i < LIMIT_REGS; i++) begin
               if (csr_index == CSR_LIMIT_FIRST + CSR_IDX_W'(i)) begin
                  limit_ff[i] <= csr_data;
               end
            end
         end
         start_time_ff <= start_time_in;
         prev_time_ff  <= prev_time_in;
         peak_ff       <= peak_in;
         finished_ff   <= finished_in;
         s1_op_ff      <= s1_op_in;
         valid_ff      <= valid_in;
         fwd_valid_ff  <= fwd_valid_in;
         rsp_wr_ff     <= rsp_wr_in;
         rsp_rd_ff     <= rsp_rd_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_bin_ff   <= rd_addr;
      s1_sel_ff   <= req_sel;
      s1_gap_ff   <= gap;
      s1_stamp_ff <= req_stamp;
      s1_peak_ff  <= peak_ff;
      s1_fin_ff   <= finished_ff;
   end

   // read, modify, write back
   always_ff @(posedge clock) begin
      rd_word_ff   <= bin_mem[rd_addr];
      stamp_row_ff <= stamp_mem[rd_addr];
      if (do_write) begin
         bin_mem[s1_bin_ff] <= wr_word;
         if (stamp_we) begin
            stamp_mem[s1_bin_ff][wr_slot] <= s1_stamp_ff;
         end
      end
   end

   assign s1_hit    = fwd_valid_ff && (fwd_bin_ff == s1_bin_ff);
   assign cur_word  = s1_hit ? fwd_word_ff : (valid_ff[s1_bin_ff] ? rd_word_ff : '0);
   assign cur_total = cur_word[STAMP_W-1:0];
   assign cur_count = cur_word[2*STAMP_W-1:STAMP_W];
   assign cur_fill  = cur_word[ENTRY_W-1:2*STAMP_W];

   always_comb begin
      for (int k = 0; k < RECENT_DEPTH; k++) begin
         if (s1_hit && fwd_stamp_we_ff && (fwd_slot_ff == SLOT_W'(k))) begin
            cur_row[k] = fwd_stamp_ff;
         end else begin
            cur_row[k] = stamp_row_ff[k];
         end
      end
   end

   assign do_write = (s1_op_ff == OP_COUNT);
   assign stamp_we = cur_fill < FILL_W'(RECENT_DEPTH);
   assign wr_slot  = SLOT_W'(cur_fill);
   assign wr_word  = {cur_fill + FILL_W'(stamp_we), cur_count + STAMP_W'(1),
                      cur_total + s1_gap_ff};

   always_comb begin
      valid_in = valid_ff;
      if (s1_op_ff == OP_CLEAR) begin
         valid_in = '0;
      end else if (do_write) begin
         valid_in[s1_bin_ff] = 1'b1;
      end
   end

   assign fwd_valid_in = do_write;

   always_ff @(posedge clock) begin
      fwd_bin_ff      <= s1_bin_ff;
      fwd_word_ff     <= wr_word;
      fwd_stamp_we_ff <= stamp_we;
      fwd_slot_ff     <= wr_slot;
      fwd_stamp_ff    <= s1_stamp_ff;
   end

   // assemble the read result
   assign sel_ok   = {1'b0, s1_sel_ff} < 4'(BIN_COUNT);
   assign fill_ext = 8'(cur_fill);
   assign shown    = !sel_ok ? 8'd0 :
                     (fill_ext > 8'(OUT_SLOTS)) ? 8'(OUT_SLOTS) : fill_ext;

   for (genvar k = 0; k < OUT_SLOTS; k++) begin : g_recent
      if (k < RECENT_DEPTH) begin : g_slot
         assign recent[k] = (8'(k) < shown) ? cur_row[k] : '0;
      end else begin : g_none
         assign recent[k] = '0;
      end
   end

   assign rsp_word = {4'd0, s1_fin_ff, s1_peak_ff,
                      recent[5], recent[4], recent[3], recent[2], recent[1], recent[0],
                      shown[RCNT_W-1:0],
                      sel_ok ? cur_count : {STAMP_W{1'b0}},
                      sel_ok ? cur_total : {STAMP_W{1'b0}}};

   // result queue
   assign rsp_push   = (s1_op_ff == OP_REPORT);
   assign rsp_pop    = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (rsp_count_ff != 2'd0);
   assign rsp_tdata  = rsp_mem_ff[rsp_rd_ff];

   always_comb begin
      rsp_wr_in    = rsp_wr_ff;
      rsp_rd_in    = rsp_rd_ff;
      rsp_count_in = rsp_count_ff;
      if (rsp_push) begin
         rsp_wr_in = (rsp_wr_ff == 2'(RSP_DEPTH - 1)) ? 2'd0 : rsp_wr_ff + 2'd1;
      end
      if (rsp_pop) begin
         rsp_rd_in = (rsp_rd_ff == 2'(RSP_DEPTH - 1)) ? 2'd0 : rsp_rd_ff + 2'd1;
      end
      case ({rsp_push, rsp_pop})
         2'b10:   rsp_count_in = rsp_count_ff + 2'd1;
         2'b01:   rsp_count_in = rsp_count_ff - 2'd1;
         default: rsp_count_in = rsp_count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rsp_mem_ff[rsp_wr_ff] <= rsp_word;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (rsp_count_ff != 2'(RSP_DEPTH)) || rsp_pop)
      else $error("result queue overflow");

   a_clear_bins: assert property (@(posedge clock) disable iff (reset)
      (s1_op_ff == OP_CLEAR) |=> (valid_ff == '0) && !fwd_valid_ff)
      else $error("bins not cleared after start");

   a_fwd_source: assert property (@(posedge clock) disable iff (reset)
      fwd_valid_ff |-> $past(s1_op_ff == OP_COUNT))
      else $error("forwarding without a preceding write");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_kind == KIND_SAMPLE) && !finished_ff
       && (elapsed >= duration_ff)) |=> finished_ff && (s1_op_ff == OP_IDLE))
      else $error("run did not end");

endmodule

// ===== dv/latency_histogram_binner_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the latency histogram binner: stream stimulus, bin predictor, checks.
module latency_histogram_binner_tb;
   import lhb_pkg::*;

   localparam int NBINS  = 8;
   localparam int NSLOTS = 6;
   localparam int QUIET_LIMIT = 3000;
   localparam int LONG_HOLD   = 400;
   localparam logic [KIND_W-1:0]    KIND_UNUSED     = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 4'd8;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 4'd15;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [63:0]       stamp;
      logic [SEL_W-1:0]  sel;
   } req_item_type;

   typedef struct packed {
      logic [63:0]       total;
      logic [63:0]       count;
      logic [RCNT_W-1:0] filled;
      logic [5:0][63:0]  recent;
      logic [63:0]       peak;
      logic              done;
   } bin_report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [STAMP_W-1:0]    csr_data = '0;

   latency_histogram_binner DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // histogram predictor state
   logic [63:0] run_len = 64'd0;
   logic [63:0] bin_limit [LIMIT_REGS] = '{default: ALL_ONES};
   logic [63:0] t_start = 64'd0;
   logic [63:0] t_prev = 64'd0;
   logic        run_done = 1'b1;
   logic [63:0] peak = 64'd0;
   logic [63:0] hits [NBINS] = '{default: 64'd0};
   logic [63:0] sums [NBINS] = '{default: 64'd0};
   int          fill [NBINS] = '{default: 0};
   logic [63:0] held [NBINS][NSLOTS];

   req_item_type   pend [$];
   bin_report_type report_q [$];
   logic [63:0]    plan_limit [LIMIT_REGS];

   int items_queued = 0;
   int items_done = 0;
   int reports_seen = 0;
   int csr_writes = 0;
   int errors = 0;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic apply_request(input req_item_type it);
      logic [63:0]    since;
      logic [63:0]    gap;
      int             b;
      bin_report_type r;
      case (it.kind)
         KIND_START: begin
            for (int i = 0; i < NBINS; i++) begin
               hits[i] = 64'd0;
               sums[i] = 64'd0;
               fill[i] = 0;
            end
            t_start = it.stamp;
            t_prev = it.stamp;
            peak = 64'd0;
            run_done = 1'b0;
         end
         KIND_SAMPLE: begin
            if (!run_done) begin
               since = it.stamp - t_start;
               if (since >= run_len) begin
                  run_done = 1'b1;
               end else begin
                  gap = it.stamp - t_prev;
                  b = NBINS - 1;
                  for (int i = NBINS - 2; i >= 0; i--)
                     if (gap <= bin_limit[i]) b = i;
                  hits[b] = hits[b] + 64'd1;
                  sums[b] = sums[b] + gap;
                  if (fill[b] < NSLOTS) begin
                     held[b][fill[b]] = it.stamp;
                     fill[b] = fill[b] + 1;
                  end
                  if (gap > peak) peak = gap;
                  t_prev = it.stamp;
               end
            end
         end
         KIND_READ: begin
            r = '0;
            r.total = sums[it.sel];
            r.count = hits[it.sel];
            r.filled = RCNT_W'(fill[it.sel]);
            for (int k = 0; k < fill[it.sel]; k++)
               r.recent[k] = held[it.sel][k];
            r.peak = peak;
            r.done = run_done;
            report_q.push_back(r);
         end
         default: ;
      endcase
   endtask

   task automatic push_item(input logic [KIND_W-1:0] kind, input logic [63:0] stamp,
                            input logic [SEL_W-1:0] sel);
      req_item_type it;
      it.kind = kind;
      it.stamp = stamp;
      it.sel = sel;
      pend.push_back(it);
      items_queued++;
   endtask

   function automatic logic [63:0] next_gap();
      logic [63:0] lim;
      logic [63:0] step;
      lim = bin_limit[$urandom_range(0, LIMIT_REGS - 1)];
      step = 64'($urandom_range(0, 2));
      case ($urandom_range(0, 9))
         0: return 64'd0;
         1: return rand64();
         2, 3, 4, 5: return lim + 64'd1 - step;
         default: begin
            step = 64'($urandom_range(0, 300));
            return step;
         end
      endcase
   endfunction

   task automatic gen_runs(input int total, input int run_min, input int run_max);
      int          made;
      int          n;
      int          pick;
      logic [63:0] t;
      made = 0;
      while (made < total) begin
         if ($urandom_range(0, 3) == 0) t = ALL_ONES - 64'($urandom_range(0, 4000));
         else t = rand64();
         push_item(KIND_START, t, SEL_W'($urandom_range(0, 7)));
         made++;
         n = $urandom_range(run_min, run_max);
         for (int i = 0; i < n && made < total; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
               t = t + next_gap();
               push_item(KIND_SAMPLE, t, SEL_W'($urandom_range(0, 7)));
            end else if (pick < 94) begin
               push_item(KIND_READ, rand64(), SEL_W'($urandom_range(0, 7)));
            end else if (pick < 97) begin
               push_item(KIND_SAMPLE, rand64(), SEL_W'($urandom_range(0, 7)));
            end else begin
               push_item(KIND_UNUSED, rand64(), SEL_W'($urandom_range(0, 7)));
            end
            made++;
         end
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_RUN_DURATION)
         run_len = val;
      else if (idx >= CSR_LIMIT_FIRST && idx < CSR_LIMIT_FIRST + LIMIT_REGS)
         bin_limit[idx - CSR_LIMIT_FIRST] = val;
      csr_writes++;
   endtask

   task automatic program_regs(input logic [63:0] dur);
      write_csr(CSR_RUN_DURATION, dur);
      for (int i = 0; i < LIMIT_REGS; i++)
         write_csr(CSR_LIMIT_FIRST + CSR_IDX_W'(i), plan_limit[i]);
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      while (items_done != items_queued || report_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // request driver
   req_item_type offer;
   int           burst_left = 0;
   int           gap_left = 0;

   always @(posedge clock) begin : drive_req
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            apply_request(offer);
            items_done++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pend.size() > 0) begin
               offer = pend.pop_front();
               req_tuser <= offer.kind;
               req_tdata <= {5'd0, offer.sel, offer.stamp};
               next_valid = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         req_tvalid <= next_valid;
      end
   end

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   // result monitor and receiver stall pattern
   int  stall_tick = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   always @(posedge clock) begin : watch_rsp
      bin_report_type        want;
      logic [RSP_DATA_W-1:0] got;
      logic                  ready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            reports_seen++;
            if (report_q.size() == 0) begin
               $display("%0t: unexpected bin report, expected none actual %h", $time, got);
               errors++;
            end else begin
               want = report_q.pop_front();
               check_field("gap_sum", want.total, got[63:0]);
               check_field("gap_tally", want.count, got[127:64]);
               check_field("recent_count", 64'(want.filled), 64'(got[130:128]));
               for (int k = 0; k < NSLOTS; k++)
                  check_field($sformatf("recent_time_%0d", k), want.recent[k],
                              got[131 + 64 * k +: 64]);
               check_field("largest_gap", want.peak, got[578:515]);
               check_field("run_finished", 64'(want.done), 64'(got[579]));
            end
         end
         stall_tick++;
         if (!hold_done && items_done >= 150) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready = 1'b0;
         end else begin
            case ((stall_tick >> 7) & 3)
               0: ready = 1'b1;
               1: ready = ($urandom_range(0, 1) == 0);
               2: ready = ((stall_tick & 3) == 0);
               default: ready = ($urandom_range(0, 4) != 0);
            endcase
         end
         rsp_tready <= ready;
      end
   end

   // watchdog on cycles without any transaction
   int quiet_cycles = 0;

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [63:0] t;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < LIMIT_REGS; i++) plan_limit[i] = 64'd10 << i;
      plan_limit[LIMIT_REGS - 1] = 64'd640;
      program_regs(64'd2000);

      // idle histogram, then a run that wraps past all-ones
      push_item(KIND_READ, 64'd0, 3'd0);
      push_item(KIND_SAMPLE, 64'd123, 3'd0);
      push_item(KIND_UNUSED, ALL_ONES, 3'd7);
      t = ALL_ONES - 64'd7;
      push_item(KIND_START, t, 3'd0);
      push_item(KIND_SAMPLE, t, 3'd0);
      for (int i = 0; i < 5; i++) begin
         t = t + 64'd5;
         push_item(KIND_SAMPLE, t, 3'd0);
      end
      t = t + 64'd10;
      push_item(KIND_SAMPLE, t, 3'd0);
      t = t + 64'd11;
      push_item(KIND_SAMPLE, t, 3'd0);
      t = t + 64'd700;
      push_item(KIND_SAMPLE, t, 3'd7);
      t = t + 64'd640;
      push_item(KIND_SAMPLE, t, 3'd0);
      push_item(KIND_READ, 64'd0, 3'd0);
      push_item(KIND_READ, ALL_ONES, 3'd1);
      push_item(KIND_READ, 64'd0, 3'd6);
      push_item(KIND_READ, 64'd0, 3'd7);
      push_item(KIND_READ, 64'd0, 3'd3);
      push_item(KIND_SAMPLE, ALL_ONES - 64'd7 + 64'd2000, 3'd0);
      push_item(KIND_SAMPLE, ALL_ONES - 64'd7 + 64'd2001, 3'd7);
      push_item(KIND_READ, 64'd0, 3'd0);
      push_item(KIND_START, 64'd0, 3'd0);
      push_item(KIND_READ, 64'd0, 3'd5);
      push_item(KIND_SAMPLE, ALL_ONES, 3'd0);
      push_item(KIND_READ, 64'd0, 3'd0);
      settle();

      // geometric limits, longest run
      for (int i = 0; i < LIMIT_REGS; i++) plan_limit[i] = (64'd1 << (3 * i + 3)) - 64'd1;
      program_regs(ALL_ONES);
      gen_runs(130, 15, 60);
      settle();

      // zero limits, zero duration
      for (int i = 0; i < LIMIT_REGS; i++) plan_limit[i] = 64'd0;
      program_regs(64'd0);
      gen_runs(60, 3, 10);
      settle();

      // every gap fits the first bin, short run
      for (int i = 0; i < LIMIT_REGS; i++) plan_limit[i] = ALL_ONES;
      program_regs(64'($urandom_range(500, 3000)));
      gen_runs(100, 10, 40);
      settle();

      // unordered random limits, random duration, unmapped indexes
      for (int i = 0; i < LIMIT_REGS; i++)
         plan_limit[i] = ($urandom_range(0, 2) == 0) ? 64'($urandom_range(0, 400)) : rand64();
      write_csr(CSR_UNMAPPED_LO, rand64());
      write_csr(CSR_UNMAPPED_HI, rand64());
      program_regs(rand64());
      gen_runs(100, 10, 40);
      settle();

      // moderate ordered limits
      for (int i = 0; i < LIMIT_REGS; i++)
         plan_limit[i] = 64'd20 * 64'(i + 1) + 64'($urandom_range(0, 9));
      program_regs(64'd4000);
      gen_runs(130, 20, 50);
      settle();

      $display("covered %0d request transactions and %0d bin reports over %0d register writes",
               items_done, reports_seen, csr_writes);
      $display("settings spanned zero, random and all-ones limits; one long result stall");
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
